FILE: hw/rtl/sha512hc_pkg.sv
// ----------------------------------------------------------------------------
// sha512hc_pkg
// Shared types, constants and round functions of the SHA-512 hash core.
// ----------------------------------------------------------------------------
package sha512hc_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  // queued work for the back end
  typedef struct packed {
    logic [63:0] word;      // already masked and padded
    logic        last;
    logic        pad_next;  // full last word: padding byte goes in the next word
    logic [63:0] len_bits;
  } q_entry_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  localparam int unsigned QDepth = 2;
  localparam logic [63:0] PadWord = 64'h8000_0000_0000_0000;
  localparam logic [6:0]  LastRound = 7'd79;

  localparam logic [7:0][63:0] InitHash = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f,
    64'h510e527fade682d1, 64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
    64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] bsig0(input logic [63:0] x);
    bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] bsig1(input logic [63:0] x);
    bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] ssig0(input logic [63:0] x);
    ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] ssig1(input logic [63:0] x);
    ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] t);
    case (t)
      7'd0:  round_k = 64'h428a2f98d728ae22;  7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;  7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538;  7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b;  7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242;  7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c;  7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f;  7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235;  7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2;  7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5;  7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275;  7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4;  7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab;  7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f;  7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2;  7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f;  7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc;  7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed;  7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de;  7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6;  7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364;  7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791;  7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218;  7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a;  7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8;  7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99;  7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63;  7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373;  7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc;  7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72;  7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28;  7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915;  7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c;  7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e;  7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba;  7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae;  7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84;  7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc;  7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6;  7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec;  7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = '0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/sha512hc_front.sv
// ----------------------------------------------------------------------------
// sha512hc_front
// Accepts message items, keeps the byte count, masks the tail and places the
// padding byte, then queues the word for the compression engine.
// ----------------------------------------------------------------------------
module sha512hc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha512hc_pkg::in_item_t in_item_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output sha512hc_pkg::q_entry_t q_entry_o
);

  logic [60:0] cnt_q, cnt_d;
  logic [3:0]  nb;
  logic [60:0] cnt_sum;
  logic [63:0] word;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    if (!in_item_i.last_word || in_item_i.valid_bytes > 4'd8) begin
      nb = 4'd8;
    end else begin
      nb = in_item_i.valid_bytes;
    end
    cnt_sum = cnt_q + 61'(nb);
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < nb) begin
        word[63 - 8*b -: 8] = in_item_i.message_word[63 - 8*b -: 8];
      end else if (4'(b) == nb) begin
        word[63 - 8*b -: 8] = 8'h80;
      end else begin
        word[63 - 8*b -: 8] = 8'h00;
      end
    end
    if (!in_item_i.last_word) begin
      word = in_item_i.message_word;
    end
    q_entry_o.word     = word;
    q_entry_o.last     = in_item_i.last_word;
    q_entry_o.pad_next = in_item_i.last_word && (nb == 4'd8);
    q_entry_o.len_bits = {cnt_sum, 3'b000};
    cnt_d = cnt_q;
    if (q_push_o) begin
      cnt_d = in_item_i.last_word ? '0 : cnt_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/sha512hc_fifo.sv
// ----------------------------------------------------------------------------
// sha512hc_fifo
// Short queue between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sha512hc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sha512hc_pkg::q_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output sha512hc_pkg::q_entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(sha512hc_pkg::QDepth);

  sha512hc_pkg::q_entry_t mem_q [sha512hc_pkg::QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(sha512hc_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

FILE: hw/rtl/sha512hc_engine.sv
// ----------------------------------------------------------------------------
// sha512hc_engine
// Block buffer, padding sequencer, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha512hc_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  sha512hc_pkg::q_entry_t  q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sha512hc_pkg::out_item_t out_item_o
);

  sha512hc_pkg::state_e state_q, state_d;
  logic [7:0][63:0]  h_q, h_d, hsum;
  logic [7:0][63:0]  v_q, v_d;
  logic [15:0][63:0] w_q, w_d;
  logic [3:0]  slot_q, slot_d;
  logic [6:0]  rnd_q, rnd_d;
  logic        pad_pend_q, pad_pend_d;
  logic        pad_phase_q, pad_phase_d;
  logic        len_ok_q, len_ok_d;
  logic        done_q, done_d;
  logic [63:0] len_q, len_d;
  logic        ovalid_q, ovalid_d;
  logic [63:0] oword_q, oword_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        push;
  logic [63:0] push_word;
  logic [63:0] wnext, t1, t2;

  assign out_valid_o             = ovalid_q;
  assign out_item_o.digest_word  = oword_q;
  assign out_item_o.digest_index = oidx_q;
  assign out_item_o.digest_last  = (oidx_q == 3'd7);

  always_comb begin
    wnext = sha512hc_pkg::ssig1(w_q[14]) + w_q[9] + sha512hc_pkg::ssig0(w_q[1]) + w_q[0];
    t1 = v_q[7] + sha512hc_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + sha512hc_pkg::round_k(rnd_q) + w_q[0];
    t2 = sha512hc_pkg::bsig0(v_q[0])
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    for (int i = 0; i < 8; i++) begin
      hsum[i] = h_q[i] + v_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    v_d         = v_q;
    w_d         = w_q;
    slot_d      = slot_q;
    rnd_d       = rnd_q;
    pad_pend_d  = pad_pend_q;
    pad_phase_d = pad_phase_q;
    len_ok_d    = len_ok_q;
    done_d      = done_q;
    len_d       = len_q;
    ovalid_d    = ovalid_q;
    oword_d     = oword_q;
    oidx_d      = oidx_q;
    push        = 1'b0;
    push_word   = '0;
    q_pop_o     = 1'b0;

    case (state_q)
      sha512hc_pkg::S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o     = 1'b1;
          push        = 1'b1;
          push_word   = q_entry_i.word;
          pad_pend_d  = q_entry_i.pad_next;
          pad_phase_d = q_entry_i.last;
          len_d       = q_entry_i.len_bits;
          len_ok_d    = 1'b0;
          if (slot_q == 4'd15) begin
            state_d = sha512hc_pkg::S_ROUND;
          end else if (q_entry_i.last) begin
            state_d = sha512hc_pkg::S_PAD;
          end
        end
      end
      sha512hc_pkg::S_PAD: begin
        push = 1'b1;
        if (pad_pend_q) begin
          push_word  = sha512hc_pkg::PadWord;
          pad_pend_d = 1'b0;
        end else if (slot_q == 4'd15 && len_ok_q) begin
          push_word = len_q;
          done_d    = 1'b1;
        end else begin
          push_word = '0;
          // the zero word in front of the length field
          if (slot_q == 4'd14) begin
            len_ok_d = 1'b1;
          end
        end
        if (slot_q == 4'd15) begin
          state_d = sha512hc_pkg::S_ROUND;
        end
      end
      sha512hc_pkg::S_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[15] = wnext;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        if (rnd_q == sha512hc_pkg::LastRound) begin
          rnd_d   = '0;
          state_d = sha512hc_pkg::S_ADD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      sha512hc_pkg::S_ADD: begin
        h_d = hsum;
        if (done_q) begin
          state_d  = sha512hc_pkg::S_OUT;
          ovalid_d = 1'b1;
          oword_d  = hsum[0];
          oidx_d   = '0;
        end else if (pad_phase_q) begin
          state_d = sha512hc_pkg::S_PAD;
        end else begin
          state_d = sha512hc_pkg::S_IDLE;
        end
      end
      sha512hc_pkg::S_OUT: begin
        if (!out_stall_i) begin
          if (oidx_q == 3'd7) begin
            ovalid_d    = 1'b0;
            h_d         = sha512hc_pkg::InitHash;
            done_d      = 1'b0;
            pad_phase_d = 1'b0;
            len_ok_d    = 1'b0;
            state_d     = sha512hc_pkg::S_IDLE;
          end else begin
            oidx_d  = oidx_q + 3'd1;
            oword_d = h_q[oidx_q + 3'd1];
          end
        end
      end
      default: begin
        state_d = sha512hc_pkg::S_IDLE;
      end
    endcase

    if (push) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = push_word;
      slot_d  = slot_q + 4'd1;
      if (slot_q == 4'd15) begin
        v_d = h_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    w_q     <= w_d;
    len_q   <= len_d;
    oword_q <= oword_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha512hc_pkg::S_IDLE;
      h_q         <= sha512hc_pkg::InitHash;
      slot_q      <= '0;
      rnd_q       <= '0;
      pad_pend_q  <= 1'b0;
      pad_phase_q <= 1'b0;
      len_ok_q    <= 1'b0;
      done_q      <= 1'b0;
      ovalid_q    <= 1'b0;
      oidx_q      <= '0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      slot_q      <= slot_d;
      rnd_q       <= rnd_d;
      pad_pend_q  <= pad_pend_d;
      pad_phase_q <= pad_phase_d;
      len_ok_q    <= len_ok_d;
      done_q      <= done_d;
      ovalid_q    <= ovalid_d;
      oidx_q      <= oidx_d;
    end
  end

  a_out_only_in_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == sha512hc_pkg::S_OUT)
    else $error("digest valid outside output state");

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha512hc_pkg::S_ROUND |-> rnd_q <= sha512hc_pkg::LastRound)
    else $error("round counter out of range");

  a_done_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha512hc_pkg::S_ADD && done_q) |=> state_q == sha512hc_pkg::S_OUT)
    else $error("final block did not lead to digest output");

  a_compress_block_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == sha512hc_pkg::S_ROUND) |-> slot_q == 4'd0 && rnd_q == 7'd0)
    else $error("compression started on a partial block");

endmodule

FILE: hw/rtl/sha512_hash_core.sv
// A non-last item is queued through the front end; a full block is loaded word
// by word, then goes through the rounds and the hash update. A last item is
// followed by padding words, one or two compressions, then 8 digest items.
// The engine, with its single shared round unit, takes no new words while it
// compresses a block, and the input stalls while the queue is full. Reset:
// asynchronous, active low; clears the queue and counters and loads the initial hash value.
// ----------------------------------------------------------------------------
// sha512_hash_core
// SHA-512 over a stream of big-endian message words, eight digest items out.
// ----------------------------------------------------------------------------
module sha512_hash_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sha512hc_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sha512hc_pkg::out_item_t out_item_o
);

  logic                   q_push, q_full, q_pop, q_valid;
  sha512hc_pkg::q_entry_t q_wr, q_rd;

  sha512hc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wr)
  );

  sha512hc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_rd)
  );

  sha512hc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_rd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the SHA-512 core on random and directed messages against a built-in
// digest predictor, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned IdleLimit = 20000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  sha512hc_pkg::in_item_t  in_item_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  sha512hc_pkg::out_item_t out_item_o;

  sha512_hash_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // predictor state
  logic [63:0] hash_h [8];
  logic [63:0] blk_w [16];
  logic [60:0] byte_cnt;
  int unsigned slot;

  sha512hc_pkg::in_item_t  pending_q [$];
  sha512hc_pkg::out_item_t digest_q [$];
  int unsigned errors = 0;
  bit stim_done = 0;
  bit hold_long = 0;
  bit wait_drain = 0;

  function automatic logic [63:0] ror64(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] kconst(int unsigned t);
    logic [63:0] k [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    return k[t];
  endfunction

  function automatic void iv_load();
    hash_h = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
               64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
               64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    byte_cnt = '0;
    slot = 0;
  endfunction

  function automatic void compress();
    logic [63:0] v [8];
    logic [63:0] w, t1, t2, x2, x15;
    v = hash_h;
    for (int t = 0; t < 80; t++) begin
      if (t < 16) w = blk_w[t];
      else begin
        x2  = blk_w[(t - 2) & 15];
        x15 = blk_w[(t - 15) & 15];
        w = (ror64(x2, 19) ^ ror64(x2, 61) ^ (x2 >> 6)) + blk_w[(t - 7) & 15]
          + (ror64(x15, 1) ^ ror64(x15, 8) ^ (x15 >> 7)) + blk_w[t & 15];
        blk_w[t & 15] = w;
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endfunction

  function automatic void put_word(logic [63:0] w);
    blk_w[slot] = w;
    slot = (slot + 1) & 15;
    if (slot == 0) compress();
  endfunction

  function automatic void predict_digest(sha512hc_pkg::in_item_t it);
    int unsigned n;
    logic [63:0] w;
    sha512hc_pkg::out_item_t o;
    n = it.valid_bytes;
    if (!it.last_word || n > 8) n = 8;
    byte_cnt = byte_cnt + 61'(n);
    w = it.message_word;
    if (!it.last_word) begin
      put_word(w);
      return;
    end
    if (n == 0) w = '0;
    else if (n < 8) w = w & ({64{1'b1}} << (64 - 8 * n));
    if (n < 8) begin
      w = w | (64'h80 << (56 - 8 * n));
      put_word(w);
    end else begin
      put_word(w);
      put_word(sha512hc_pkg::PadWord);
    end
    while (slot != 14) put_word('0);
    put_word('0);
    put_word({byte_cnt, 3'b000});
    for (int i = 0; i < 8; i++) begin
      o.digest_word  = hash_h[i];
      o.digest_index = 3'(i);
      o.digest_last  = (i == 7);
      digest_q.push_back(o);
    end
    iv_load();
  endfunction

  function automatic sha512hc_pkg::in_item_t mk(logic [63:0] w, logic [3:0] vb, logic lst);
    sha512hc_pkg::in_item_t it;
    it.message_word = w;
    it.valid_bytes  = vb;
    it.last_word    = lst;
    return it;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // random message of nw words plus a last word; last word mostly well-formed, a few with odd valid_bytes
  function automatic void queue_msg(int unsigned nw);
    for (int i = 0; i < nw; i++)
      pending_q.push_back(mk(rnd64(), 4'($urandom), 1'b0));
    if ($urandom_range(0, 9) == 0)
      pending_q.push_back(mk(rnd64(), 4'($urandom_range(0, 15)), 1'b1));
    else
      pending_q.push_back(mk(rnd64(), 4'($urandom_range(1, 8)), 1'b1));
  endfunction

  // stimulus
  initial begin
    int unsigned total;
    // empty message, short tails, full last words, over-range counts
    pending_q.push_back(mk(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1));
    pending_q.push_back(mk(64'h6162_6300_0000_0000, 4'd3, 1'b1));
    pending_q.push_back(mk(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1));
    pending_q.push_back(mk(64'h0, 4'd1, 1'b1));
    pending_q.push_back(mk(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1));
    pending_q.push_back(mk(64'hffff_ffff_ffff_ffff, 4'd7, 1'b1));
    for (int i = 0; i < 13; i++)
      pending_q.push_back(mk(i[0] ? '1 : '0, 4'(i), 1'b0));
    pending_q.push_back(mk(64'h0123_4567_89ab_cdef, 4'd8, 1'b1)); // 14 words: two blocks
    for (int i = 0; i < 3; i++) pending_q.push_back(mk(64'h0, 4'd9, 1'b0));
    pending_q.push_back(mk(64'h0, 4'd5, 1'b1));
    total = pending_q.size();
    while (total < 380) begin
      int unsigned nw;
      nw = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 16);
      queue_msg(nw);
      total = total + nw + 1;
    end
  end

  // driver: bursts and gaps
  int unsigned burst_left = 0, gap_left = 0, accepted = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_digest(in_item_i);
        accepted <= accepted + 1;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the offered item
      end else if (wait_drain || pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (pending_q.size() == 0) stim_done <= 1'b1;
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_q.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // a pause of the sender once 150 items are accepted, until everything has drained
  always @(posedge clk_i) begin
    if (rst_ni && accepted == 150 && !wait_drain) wait_drain <= 1'b1;
    else if (wait_drain && digest_q.size() == 0 && !in_valid_i) wait_drain <= 1'b0;
  end

  // receiver stall pattern, with one long hold-off
  int unsigned stall_cyc = 0, phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      phase <= phase + 1;
      if (accepted >= 60 && accepted < 70 && stall_cyc == 0 && !hold_long) begin
        hold_long <= 1'b1;
        stall_cyc <= 3000;
        out_stall_i <= 1'b1;
      end else if (stall_cyc > 1) begin
        stall_cyc <= stall_cyc - 1;
        out_stall_i <= 1'b1;
      end else if (phase % 512 < 128) begin
        stall_cyc <= 0;
        out_stall_i <= 1'b0;
      end else begin
        stall_cyc <= 0;
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sha512hc_pkg::out_item_t exp_d;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest item %h", $realtime, out_item_o);
        errors++;
      end else begin
        exp_d = digest_q.pop_front();
        if (out_item_o.digest_word !== exp_d.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $realtime,
                   exp_d.digest_word, out_item_o.digest_word);
          errors++;
        end
        if (out_item_o.digest_index !== exp_d.digest_index) begin
          $display("%0t: digest_index expected %0d actual %0d", $realtime,
                   exp_d.digest_index, out_item_o.digest_index);
          errors++;
        end
        if (out_item_o.digest_last !== exp_d.digest_last) begin
          $display("%0t: digest_last expected %0d actual %0d", $realtime,
                   exp_d.digest_last, out_item_o.digest_last);
          errors++;
        end
      end
    end
  end

  // watchdog and end of run
  int unsigned quiet = 0, tail = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else if (stim_done && !in_valid_i && digest_q.size() == 0) begin
      tail <= tail + 1;
      if (tail == 400) begin
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    iv_load();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

endmodule
